[rtl/core/csc_pkg.sv]
`timescale 1ns / 1ps
// Shared constants and the arctangent table for the CORDIC sine/cosine core.
// No dependencies.
package csc_pkg;

    localparam int unsigned DATA_W      = 16;
    localparam int unsigned CNT_W       = 5;
    localparam int unsigned TABLE_STEPS = 16;

    // 16384 / CORDIC gain
    localparam logic signed [DATA_W-1:0] INV_GAIN_Q14 = 16'sd9949;
    localparam logic [CNT_W-1:0]         MAX_STEPS    = CNT_W'(TABLE_STEPS);
    localparam int unsigned              SIGN_POS     = DATA_W - 1;

    // atan(2^-k) * 16384, truncated
    function automatic logic signed [DATA_W-1:0] atan_q14(input int unsigned k);
        logic signed [DATA_W-1:0] val;
        unique case (k)
            0:       val = 16'sd12867;
            1:       val = 16'sd7596;
            2:       val = 16'sd4013;
            3:       val = 16'sd2037;
            4:       val = 16'sd1022;
            5:       val = 16'sd511;
            6:       val = 16'sd255;
            7:       val = 16'sd127;
            8:       val = 16'sd63;
            9:       val = 16'sd31;
            10:      val = 16'sd15;
            11:      val = 16'sd7;
            12:      val = 16'sd3;
            13:      val = 16'sd1;
            default: val = 16'sd0;
        endcase
        return val;
    endfunction

endpackage

[rtl/core/cordic_sine_cosine_q14.sv]
`timescale 1ns / 1ps
// Pipelined rotation-mode CORDIC: angle in, cosine and sine out, Q14.
// Depends on csc_pkg.

// The block takes one signed angle per item (radians * 16384, meant for
// -pi/2..pi/2) and returns one item holding cosine and sine in Q14. It
// accepts a new item every clock cycle unless a stall on m_ready holds it. There
// are 16 register stages, one per CORDIC step, and the first one loads at the
// input accept edge. Each stage holds one shift-add step (a 16-bit add on
// x, y and z with a fixed shift), so the stage depth sets the
// clock. Every stage has its own valid bit and
// loads when it is empty or its successor moves, so bubbles collapse and a
// stall on m_ready backs up stage by stage without losing or repeating an
// item; the last stage is the output register. The step count register
// (cfg_iteration_count, reset 16, values above 16 act as 16) is sampled as
// an item enters and travels with it; steps at or past the count pass the
// vector through unchanged. With a count of zero the output is 9949 / 0.
// Angles outside the valid range give wrapped, but defined, results.
// cfg_ready is always high; write the count only while the pipeline is empty.
module cordic_sine_cosine_q14 (
    input  logic                                aclk,
    input  logic                                aresetn,
    // step count register
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [csc_pkg::CNT_W-1:0]           cfg_iteration_count,
    // angle items
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [csc_pkg::DATA_W-1:0]   s_theta,
    // result items
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [csc_pkg::DATA_W-1:0]   m_cosine,
    output logic signed [csc_pkg::DATA_W-1:0]   m_sine
);

    localparam int unsigned STEPS = csc_pkg::TABLE_STEPS;

    logic [csc_pkg::CNT_W-1:0] count_reg;
    logic [csc_pkg::CNT_W-1:0] count_clamped;

    // per-stage state
    logic                             vld_reg [STEPS];
    logic signed [csc_pkg::DATA_W-1:0] x_reg [STEPS];
    logic signed [csc_pkg::DATA_W-1:0] y_reg [STEPS];
    logic signed [csc_pkg::DATA_W-1:0] z_reg [STEPS];
    logic [csc_pkg::CNT_W-1:0]         n_reg [STEPS];
    logic                             load  [STEPS];

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= csc_pkg::MAX_STEPS;
        end else if (cfg_valid) begin
            count_reg <= cfg_iteration_count;
        end
    end

    assign count_clamped = (count_reg > csc_pkg::MAX_STEPS) ? csc_pkg::MAX_STEPS
                                                             : count_reg;

    genvar k;
    generate
        for (k = 0; k < STEPS; k++) begin : g_step
            logic                              vld_in;
            logic signed [csc_pkg::DATA_W-1:0] x_in;
            logic signed [csc_pkg::DATA_W-1:0] y_in;
            logic signed [csc_pkg::DATA_W-1:0] z_in;
            logic [csc_pkg::CNT_W-1:0]         n_in;
            logic                              advance;
            logic                              active;
            logic                              neg;
            logic signed [csc_pkg::DATA_W-1:0] xs;
            logic signed [csc_pkg::DATA_W-1:0] ys;
            logic signed [csc_pkg::DATA_W-1:0] x_next;
            logic signed [csc_pkg::DATA_W-1:0] y_next;
            logic signed [csc_pkg::DATA_W-1:0] z_next;

            if (k == 0) begin : g_src_in
                assign vld_in = s_valid;
                assign x_in   = csc_pkg::INV_GAIN_Q14;
                assign y_in   = '0;
                assign z_in   = s_theta;
                assign n_in   = count_clamped;
            end else begin : g_src_stage
                assign vld_in = vld_reg[k-1];
                assign x_in   = x_reg[k-1];
                assign y_in   = y_reg[k-1];
                assign z_in   = z_reg[k-1];
                assign n_in   = n_reg[k-1];
            end

            if (k == STEPS - 1) begin : g_adv_out
                assign advance = m_ready;
            end else begin : g_adv_next
                assign advance = load[k+1];
            end

            // stage takes a new item when empty or when its item moves on
            assign load[k] = !vld_reg[k] || advance;

            assign active = csc_pkg::CNT_W'(k) < n_in;
            assign neg    = z_in[csc_pkg::SIGN_POS];
            assign xs     = x_in >>> k;
            assign ys     = y_in >>> k;

            always_comb begin
                if (!active) begin
                    x_next = x_in;
                    y_next = y_in;
                    z_next = z_in;
                end else if (neg) begin
                    x_next = x_in + ys;
                    y_next = y_in - xs;
                    z_next = z_in + csc_pkg::atan_q14(k);
                end else begin
                    x_next = x_in - ys;
                    y_next = y_in + xs;
                    z_next = z_in - csc_pkg::atan_q14(k);
                end
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    vld_reg[k] <= 1'b0;
                end else if (load[k]) begin
                    vld_reg[k] <= vld_in;
                end
            end

            always_ff @(posedge aclk) begin
                if (load[k] && vld_in) begin
                    x_reg[k] <= x_next;
                    y_reg[k] <= y_next;
                    z_reg[k] <= z_next;
                    n_reg[k] <= n_in;
                end
            end
        end
    endgenerate

    assign s_ready  = load[0];
    assign m_valid  = vld_reg[STEPS-1];
    assign m_cosine = x_reg[STEPS-1];
    assign m_sine   = y_reg[STEPS-1];

endmodule

[verif/cordic_sine_cosine_q14_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for cordic_sine_cosine_q14: directed and random angle items
// checked against a local shift-add rotation model. Depends on csc_pkg and the block.
module cordic_sine_cosine_q14_tb;

    localparam int unsigned DW = csc_pkg::DATA_W;
    localparam int unsigned CW = csc_pkg::CNT_W;

    // One stage per step; the last stage is the output register
    localparam int unsigned PIPE_LATENCY = 16;

    // Independent copy of the start vector and the turn-angle table, so a bad
    // constant in the RTL package shows up as a mismatch.
    localparam logic signed [DW-1:0] START_X      = 16'sd9949;
    localparam int unsigned          MAX_ROTATION = 16;
    localparam logic signed [DW-1:0] TURN_ANGLES [MAX_ROTATION] = '{
        16'sd12867, 16'sd7596, 16'sd4013, 16'sd2037, 16'sd1022, 16'sd511, 16'sd255,
        16'sd127, 16'sd63, 16'sd31, 16'sd15, 16'sd7, 16'sd3, 16'sd1, 16'sd0, 16'sd0
    };

    // pi/2 in radians * 16384, rounded down
    localparam int HALF_PI_Q14 = 25735;

    typedef struct packed {
        logic signed [DW-1:0] cosine;
        logic signed [DW-1:0] sine;
    } sincos_t;

    // ---------------------------------------------------------------------
    // Clock, reset and block I/O. Every input has a known value at time 0.
    // ---------------------------------------------------------------------
    logic                 aclk                = 1'b0;
    logic                 aresetn             = 1'b0;
    logic                 cfg_valid           = 1'b0;
    logic                 cfg_ready;
    logic [CW-1:0]        cfg_iteration_count = '0;
    logic                 s_valid             = 1'b0;
    logic                 s_ready;
    logic signed [DW-1:0] s_theta             = '0;
    logic                 m_valid;
    logic                 m_ready             = 1'b0;
    logic signed [DW-1:0] m_cosine;
    logic signed [DW-1:0] m_sine;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    cordic_sine_cosine_q14 u_dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_iteration_count (cfg_iteration_count),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_theta             (s_theta),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_cosine            (m_cosine),
        .m_sine              (m_sine)
    );

    // ---------------------------------------------------------------------
    // Testbench state
    // ---------------------------------------------------------------------
    sincos_t       expected_results[$];   // oldest at the front
    logic [CW-1:0] step_count   = CW'(16); // mirrors the register, reset value 16
    int            error_count  = 0;
    int            items_sent   = 0;
    int            results_seen = 0;
    int            count_writes = 0;
    int            sender_idle_pct  = 0;   // chance per cycle the sender holds off
    int            receiver_stall_pct = 0; // chance per cycle m_ready is low

    // ---------------------------------------------------------------------
    // Rotation model. Count is clamped to the table size; each step turns by
    // +-atan(2^-k) depending on the sign of the residual angle. All three
    // registers are 16 bits and wrap, shifts are arithmetic.
    // ---------------------------------------------------------------------
    function automatic sincos_t rotate_angle(input logic signed [DW-1:0] theta,
                                             input logic [CW-1:0] steps);
        logic signed [DW-1:0] x;
        logic signed [DW-1:0] y;
        logic signed [DW-1:0] z;
        logic signed [DW-1:0] xs;
        logic signed [DW-1:0] ys;
        int unsigned          n;
        sincos_t              r;
        x = START_X;
        y = '0;
        z = theta;
        n = (steps > MAX_ROTATION) ? MAX_ROTATION : steps;
        for (int k = 0; k < n; k++) begin
            xs = x >>> k;
            ys = y >>> k;
            if (z[DW-1]) begin
                // residual negative: turn clockwise
                x = x + ys;
                y = y - xs;
                z = z + TURN_ANGLES[k];
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - TURN_ANGLES[k];
            end
        end
        r.cosine = x;
        r.sine   = y;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic signed [DW-1:0] got,
                                   input logic signed [DW-1:0] want);
        $display("[%0t] MISMATCH %s: got %0d expected %0d", $time, what, got, want);
        error_count++;
    endtask

    // ---------------------------------------------------------------------
    // Receiver: m_ready changes on the falling edge with the current stall
    // rate; results are taken on the rising edge.
    // ---------------------------------------------------------------------
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // Result checker: every accepted result against the oldest prediction.
    always @(posedge aclk) begin
        sincos_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                $display("[%0t] MISMATCH unexpected result cos %0d sin %0d",
                         $time, m_cosine, m_sine);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                if (m_cosine !== want.cosine) report_mismatch("cosine", m_cosine, want.cosine);
                if (m_sine !== want.sine)     report_mismatch("sine", m_sine, want.sine);
            end
        end
    end

    // ---------------------------------------------------------------------
    // Sender: optional random hold-off, then present the angle and keep it
    // until accepted. Valid is left high; a hold-off in the next call or a drain
    // lowers it on a later falling edge.
    // ---------------------------------------------------------------------
    task automatic send_angle(input logic signed [DW-1:0] theta);
        @(negedge aclk);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_theta <= theta;
        do @(posedge aclk); while (!s_ready);
        // count is sampled as the item enters, same as the block
        expected_results.push_back(rotate_angle(theta, step_count));
        items_sent++;
    endtask

    // Stop sending and wait until every prediction has been matched, then let
    // the pipeline settle.
    task automatic wait_for_drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (PIPE_LATENCY + 4) @(posedge aclk);
    endtask

    // Count register write, only with the pipeline empty.
    task automatic write_step_count(input logic [CW-1:0] cnt);
        wait_for_drain();
        @(negedge aclk);
        cfg_valid           <= 1'b1;
        cfg_iteration_count <= cnt;
        do @(posedge aclk); while (!cfg_ready);
        step_count = cnt;
        count_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Mostly in-range angles, some anywhere in the 16-bit range (wrapped results)
    function automatic logic signed [DW-1:0] random_angle();
        if ($urandom_range(99) < 80)
            return DW'($signed($urandom_range(2 * HALF_PI_Q14)) - HALF_PI_Q14);
        return DW'($urandom);
    endfunction

    // ---------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------

    // Reset count of 16: field extremes, zero, +-1, the range ends, mid angles.
    task automatic test_directed_angles();
        logic signed [DW-1:0] angles [11] = '{
            16'sd0, 16'sd1, -16'sd1, 16'(HALF_PI_Q14), -16'(HALF_PI_Q14 + 1),
            16'sd12868, -16'sd12868, 16'sd16384, -16'sd16384,
            16'sh7FFF, 16'sh8000
        };
        foreach (angles[i]) send_angle(angles[i]);
    endtask

    // Zero steps (start vector passes through), all-ones count and just above
    // the table (both clamp), single step, one short of full.
    task automatic test_step_count_corners();
        write_step_count(CW'(0));
        send_angle(16'sh7FFF);
        send_angle(16'sh8000);
        write_step_count(CW'(31));
        send_angle(16'sd10000);
        send_angle(-16'sd20000);
        write_step_count(CW'(17));
        send_angle(16'sd5000);
        write_step_count(CW'(1));
        send_angle(-16'sd1);
        send_angle(16'sd25000);
        write_step_count(CW'(15));
        send_angle(16'sd3);
    endtask

    // One flow-control setting, two count settings, random angles.
    task automatic test_flow_phase(input int idle_pct, input int stall_pct,
                                   input logic [CW-1:0] cnt_a, input logic [CW-1:0] cnt_b,
                                   input int n_items);
        write_step_count(cnt_a);
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        for (int i = 0; i < n_items / 2; i++) send_angle(random_angle());
        write_step_count(cnt_b);
        for (int i = n_items / 2; i < n_items; i++) send_angle(random_angle());
        wait_for_drain();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
    endtask

    // Sender holds off until the pipeline is completely empty, then resumes
    // back to back; checks nothing is lost across a full drain.
    task automatic test_pause_and_resume();
        receiver_stall_pct = 30;
        for (int i = 0; i < 20; i++) send_angle(random_angle());
        wait_for_drain();
        for (int i = 0; i < 20; i++) send_angle(random_angle());
        wait_for_drain();
        receiver_stall_pct = 0;
    endtask

    // ---------------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------------
    initial begin
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed_angles();
        test_step_count_corners();
        // no idling, sender idle, receiver stall, both
        test_flow_phase(0, 0, CW'(16), CW'($urandom_range(31)), 300);
        test_flow_phase(71, 0, CW'(16), CW'(8), 300);
        test_flow_phase(0, 71, CW'(16), CW'($urandom_range(31)), 300);
        test_flow_phase(15, 15, CW'(12), CW'(16), 300);
        test_pause_and_resume();

        wait_for_drain();
        $display("Covered %0d angle items and %0d results over %0d step-count writes,",
                 items_sent, results_seen, count_writes);
        $display("counts 0 to 31 and four flow-control mixes; %0d mismatches", error_count);
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #5ms;
        $display("[%0t] timeout, %0d results still expected", $time, expected_results.size());
        $display("Regression FAIL");
        $finish;
    end

endmodule

[files.f]
rtl/core/csc_pkg.sv
rtl/core/cordic_sine_cosine_q14.sv
verif/cordic_sine_cosine_q14_tb.sv
